### rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

	localparam int DEF_MAX_COLS   = 128;
	localparam int DEF_MAX_ROWS   = 32;
	localparam int DEF_CELL_DEPTH = 4096;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [5:0] ROWS_RESET    = 6'd25;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;

	localparam logic [7:0]  ATTR_BYTE  = 8'h0F;
	localparam logic [15:0] BLANK_CELL = 16'h0F20;
	localparam int          CELL_W     = 16;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  char_code;
		logic        starts_string;
		logic [11:0] cell_index;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [7:0]  cursor_column;
		logic [4:0]  cursor_row;
	} result_t;

endpackage

### rtl/tcw_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/tcw_ctrl.sv
// Sequencer: cursor, item decode, scroll copy and blanking sweeps over the screen RAM.
module tcw_ctrl #(
	parameter int MAX_COLS   = tcw_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS   = tcw_pkg::DEF_MAX_ROWS,
	parameter int CELL_DEPTH = tcw_pkg::DEF_CELL_DEPTH
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              start,
	input  tcw_pkg::item_t                                    item,
	output logic                                              busy,
	output logic                                              done,
	output tcw_pkg::result_t                                  result,
	input  logic [$clog2(MAX_COLS+1)-1:0]                     eff_cols,
	input  logic [$clog2(MAX_ROWS+1)-1:0]                     eff_rows,
	input  logic [$clog2(MAX_COLS*MAX_ROWS+1)-1:0]            cell_total,
	output logic                                              mem_we,
	output logic [((CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1)-1:0] mem_waddr,
	output logic [tcw_pkg::CELL_W-1:0]                        mem_wdata,
	output logic                                              mem_re,
	output logic [((CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1)-1:0] mem_raddr,
	input  logic [tcw_pkg::CELL_W-1:0]                        mem_rdata
);
	import tcw_pkg::*;

	localparam int CW = $clog2(MAX_COLS+1);
	localparam int LW = $clog2(MAX_ROWS+1);
	localparam int TW = $clog2(MAX_COLS*MAX_ROWS+1);
	localparam int AW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SETTLE = 3'd1;
	localparam logic [2:0] S_CHAR   = 3'd2;
	localparam logic [2:0] S_WRITE  = 3'd3;
	localparam logic [2:0] S_COPY   = 3'd4;
	localparam logic [2:0] S_FILL   = 3'd5;
	localparam logic [2:0] S_READ   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]        state_q;
	logic [2:0]        ret_q;
	logic [CW-1:0]     col_q;
	logic [LW-1:0]     line_q;
	logic [7:0]        ch_q;
	logic [CELL_W-1:0] value_q;
	logic [CELL_W-1:0] wdata_q;
	logic              inc_q;
	logic [TW-1:0]     ptr_q;
	logic              rd_oor_q;
	logic              pend_s1;
	logic              oor_s1;
	logic [TW-1:0]     wa_s1;

	logic          wrap;
	logic [LW-1:0] next_line;
	logic          need_scroll;
	logic [CW-1:0] col_m1;
	logic [TW-1:0] cur_lin;
	logic          copy_issue;
	logic          idx_in_range;
	logic [TW-1:0] cols_t;

	assign cols_t       = TW'(eff_cols);
	assign wrap         = (col_q >= eff_cols);
	assign next_line    = wrap ? (line_q + 1'b1) : line_q;
	assign need_scroll  = (next_line >= eff_rows);
	assign col_m1       = col_q - 1'b1;
	assign cur_lin      = TW'(line_q) * cols_t + TW'(col_q);
	assign copy_issue   = (ptr_q < cell_total);
	assign idx_in_range = (32'(item.cell_index) < CELL_DEPTH);

	// read port: the read item in idle, the copy source otherwise
	always_comb begin
		if (state_q == S_IDLE) begin
			mem_raddr = AW'(item.cell_index);
			mem_re    = start && (item.operation == OP_READ) && idx_in_range;
		end else begin
			mem_raddr = AW'(ptr_q);
			mem_re    = (state_q == S_COPY) && copy_issue && (32'(ptr_q) < CELL_DEPTH);
		end
	end

	// write port: copy transfer in flight wins, then cursor write, then blanking
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(ptr_q);
		mem_wdata = BLANK_CELL;
		if (pend_s1) begin
			mem_we    = (32'(wa_s1) < CELL_DEPTH);
			mem_waddr = AW'(wa_s1);
			mem_wdata = oor_s1 ? '0 : mem_rdata;
		end else if (state_q == S_WRITE) begin
			mem_we    = (32'(cur_lin) < CELL_DEPTH);
			mem_waddr = AW'(cur_lin);
			mem_wdata = wdata_q;
		end else if (state_q == S_FILL) begin
			mem_we    = (32'(ptr_q) < CELL_DEPTH);
			mem_waddr = AW'(ptr_q);
			mem_wdata = BLANK_CELL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			line_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_COPY) && copy_issue;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (item.operation)
							OP_PUT: begin
								state_q <= item.starts_string ? S_SETTLE : S_CHAR;
							end
							OP_CLEAR: begin
								col_q   <= '0;
								line_q  <= '0;
								state_q <= S_FILL;
							end
							OP_READ: begin
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SETTLE: begin
					if (wrap) begin
						col_q <= '0;
					end
					if (need_scroll) begin
						line_q  <= eff_rows - 1'b1;
						state_q <= S_COPY;
					end else begin
						line_q  <= next_line;
						state_q <= ret_q;
					end
				end
				S_CHAR: begin
					unique case (ch_q)
						CH_NUL: begin
							state_q <= S_DONE;
						end
						CH_BACKSPACE: begin
							if (col_q == '0) begin
								state_q <= S_DONE;
							end else begin
								col_q   <= col_m1;
								state_q <= ((col_m1 < eff_cols) && (line_q < eff_rows)) ?
									S_WRITE : S_DONE;
							end
						end
						CH_NEWLINE: begin
							line_q  <= line_q + 1'b1;
							col_q   <= '0;
							state_q <= S_SETTLE;
						end
						CH_RETURN: begin
							col_q   <= '0;
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_SETTLE;
						end
					endcase
				end
				S_WRITE: begin
					if (inc_q) begin
						col_q <= col_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_COPY: begin
					// wait for the last copy transfer to land before blanking
					if (!copy_issue && !pend_s1) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (ptr_q == cell_total - 1'b1) begin
						state_q <= ret_q;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		oor_s1 <= (32'(ptr_q) >= CELL_DEPTH);
		wa_s1  <= ptr_q - cols_t;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					value_q  <= '0;
					ch_q     <= item.char_code;
					rd_oor_q <= !idx_in_range;
					ptr_q    <= '0;
					ret_q    <= (item.operation == OP_CLEAR) ? S_DONE : S_CHAR;
				end
			end
			S_SETTLE: begin
				ptr_q <= cols_t;
			end
			S_CHAR: begin
				unique case (ch_q)
					CH_BACKSPACE: begin
						wdata_q <= BLANK_CELL;
						inc_q   <= 1'b0;
					end
					CH_NEWLINE: begin
						ret_q <= S_DONE;
					end
					CH_NUL, CH_RETURN: begin
					end
					default: begin
						wdata_q <= {ATTR_BYTE, ch_q};
						inc_q   <= 1'b1;
						ret_q   <= S_WRITE;
					end
				endcase
			end
			S_COPY: begin
				if (copy_issue) begin
					ptr_q <= ptr_q + 1'b1;
				end else if (!pend_s1) begin
					ptr_q <= cell_total - cols_t;
				end
			end
			S_FILL: begin
				ptr_q <= ptr_q + 1'b1;
			end
			S_READ: begin
				value_q <= rd_oor_q ? '0 : mem_rdata;
			end
			S_WRITE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		result.cell_value    = value_q;
		result.cursor_column = 8'(col_q);
		result.cursor_row    = 5'(line_q);
	end

endmodule

### rtl/text_console_writer.sv
// Top level: text console writer with geometry registers, sequencer and screen RAM.
// Done strobe after the start transfer: a printable character passes decode, settle and write;
// newline decode and settle; backspace decode and write; CR, NUL, read or ignored backspace
// one decode or read state; an unused operation goes straight to done. Next start in the cycle
// after done; a string start settles first. Scroll copies rows up, blanks the last; clear all.
// Async reset: cursor home, columns 80, rows 25; screen contents undefined until written.
module text_console_writer #(
	parameter int MAX_COLS   = tcw_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS   = tcw_pkg::DEF_MAX_ROWS,
	parameter int CELL_DEPTH = tcw_pkg::DEF_CELL_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  tcw_pkg::item_t                   item,
	output logic                             busy,
	output logic                             done,
	output tcw_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tcw_pkg::*;

	localparam int CW = $clog2(MAX_COLS+1);
	localparam int LW = $clog2(MAX_ROWS+1);
	localparam int TW = $clog2(MAX_COLS*MAX_ROWS+1);
	localparam int AW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

	logic [7:0]        columns_q;
	logic [5:0]        rows_q;
	logic [CW-1:0]     eff_cols;
	logic [LW-1:0]     eff_rows;
	logic [TW-1:0]     total_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q    <= ROWS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COLUMNS: columns_q <= cfg_data;
				REG_ROWS:    rows_q    <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// out-of-range geometry saturates into 1..MAX
	always_comb begin
		if (columns_q == '0) begin
			eff_cols = CW'(1);
		end else if (32'(columns_q) > MAX_COLS) begin
			eff_cols = CW'(MAX_COLS);
		end else begin
			eff_cols = CW'(columns_q);
		end
		if (rows_q == '0) begin
			eff_rows = LW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			eff_rows = LW'(MAX_ROWS);
		end else begin
			eff_rows = LW'(rows_q);
		end
	end

	always_ff @(posedge clk) begin
		total_q <= TW'(eff_cols) * TW'(eff_rows);
	end

	tcw_ctrl #(
		.MAX_COLS   (MAX_COLS),
		.MAX_ROWS   (MAX_ROWS),
		.CELL_DEPTH (CELL_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.busy       (busy),
		.done       (done),
		.result     (result),
		.eff_cols   (eff_cols),
		.eff_rows   (eff_rows),
		.cell_total (total_q),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_DEPTH)
	) u_screen (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after its result");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.cursor_column) <= MAX_COLS))
		else $error("cursor column beyond the widest screen");

endmodule
